[design/ccfp_pkg.sv]
// ----------------------------------------------------------------------------
// ccfp_pkg: shared types and constants of the command frame parser
// Byte codes, frame geometry, config register indexes and result kinds.
// ----------------------------------------------------------------------------
package ccfp_pkg;

  // frame geometry: letter, four value characters, cr, lf
  localparam int FrameLength = 7;
  localparam int PosWidth    = 3;
  localparam logic [PosWidth-1:0] POS_IDLE = PosWidth'(FrameLength);
  localparam logic [PosWidth-1:0] POS_CR   = PosWidth'(FrameLength - 2);
  localparam logic [PosWidth-1:0] POS_LF   = PosWidth'(FrameLength - 1);

  // field widths
  localparam int ByteWidth   = 8;
  localparam int ValueWidth  = 14;
  localparam int ZeroWidth   = 13;
  localparam int StepWidth   = 24;
  localparam int TargetWidth = 16;

  // ascii codes
  localparam logic [ByteWidth-1:0] CHAR_CR    = 8'h0D;
  localparam logic [ByteWidth-1:0] CHAR_LF    = 8'h0A;
  localparam logic [ByteWidth-1:0] CHAR_TAB   = 8'h09;
  localparam logic [ByteWidth-1:0] CHAR_SPACE = 8'h20;
  localparam logic [ByteWidth-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [ByteWidth-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [ByteWidth-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [ByteWidth-1:0] CHAR_NINE  = 8'h39;
  localparam logic [ByteWidth-1:0] CHAR_S     = 8'h53;
  localparam logic [ByteWidth-1:0] CHAR_D     = 8'h44;

  // config register indexes
  localparam int CfgIndexWidth = 2;
  localparam logic [CfgIndexWidth-1:0] CFG_MAX_VALUE  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_ZERO_VALUE = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_STEP_SCALE = 2'd2;

  // config reset values
  localparam logic [ValueWidth-1:0] MAX_VALUE_RST  = 14'd1024;
  localparam logic [ZeroWidth-1:0]  ZERO_VALUE_RST = 13'd512;
  localparam logic [StepWidth-1:0]  STEP_SCALE_RST = 24'd32768;

  // result kinds
  typedef enum logic [1:0] {
    KIND_REJECT   = 2'd0,
    KIND_SPEED    = 2'd1,
    KIND_ROTATION = 2'd2
  } kind_t;

  // atoi-style scan phases
  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_SIGNED = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

endpackage

[design/control_command_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// control_command_frame_parser_core: seven-byte ascii command frame parser
// Scans letter, four value characters and cr lf, updates speed or rotation
// target in signed q2.14 and reports one result per completed frame.
// ----------------------------------------------------------------------------
// a result shows on out_valid in the cycle after its lf byte is taken
// throughput: one byte per cycle, set by the single output register, which
//   stalls the input only while a finished result is held by out_stall
// reset: rst_n synchronous active low; no frame open, both targets zero,
//   config back to max 1024, zero 512, step 32768
module control_command_frame_parser_core
  import ccfp_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  // byte input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ByteWidth-1:0]          in_rx_byte,
  input  logic                          in_frame_start,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_command_kind,
  output logic [ValueWidth-1:0]         out_command_value,
  output logic signed [TargetWidth-1:0] out_speed_target,
  output logic signed [TargetWidth-1:0] out_rotation_target,
  // config write port
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CfgIndexWidth-1:0]      cfg_index,
  input  logic [StepWidth-1:0]          cfg_data
);

  localparam int DiffWidth = ValueWidth + 1;               // signed value - zero
  localparam int ProdWidth = DiffWidth + StepWidth + 1;    // signed product
  localparam int FracDrop  = 10;                           // q.24 -> q.14
  localparam int QWidth    = ProdWidth - FracDrop;

  // config registers
  logic [ValueWidth-1:0] max_value_r;
  logic [ZeroWidth-1:0]  zero_value_r;
  logic [StepWidth-1:0]  step_scale_r;

  // frame state
  logic [PosWidth-1:0]   pos_r,     pos_nxt;
  logic                  is_s_r,    is_s_nxt;
  logic                  is_d_r,    is_d_nxt;
  phase_t                phase_r,   phase_nxt;
  logic                  neg_r,     neg_nxt;
  logic [ValueWidth-1:0] acc_r,     acc_nxt;
  logic                  cr_r,      cr_nxt;

  // targets and result register
  logic signed [TargetWidth-1:0] speed_r, speed_nxt;
  logic signed [TargetWidth-1:0] rot_r,   rot_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    kind_r,  kind_nxt;
  logic [ValueWidth-1:0]         value_r, value_nxt;

  // datapath
  logic                  in_acc;
  logic [PosWidth-1:0]   pos_sel;
  logic                  is_digit;
  logic                  is_space;
  logic [ValueWidth-1:0] digit_val;
  logic                  frame_ok;
  logic [ValueWidth-1:0] cmd_val;
  logic signed [DiffWidth-1:0] diff;
  logic signed [ProdWidth-1:0] prod;
  logic signed [ProdWidth-1:0] prod_rnd;
  logic signed [QWidth-1:0]    q;
  logic signed [TargetWidth-1:0] target;

  // output register frees the input side unless a result is held
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid           = out_valid_r;
  assign out_command_kind    = kind_r;
  assign out_command_value   = value_r;
  // targets only move together with a new result, so they hold while stalled
  assign out_speed_target    = speed_r;
  assign out_rotation_target = rot_r;

  // config writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_value_r  <= MAX_VALUE_RST;
      zero_value_r <= ZERO_VALUE_RST;
      step_scale_r <= STEP_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_VALUE:  max_value_r  <= cfg_data[ValueWidth-1:0];
        CFG_ZERO_VALUE: zero_value_r <= cfg_data[ZeroWidth-1:0];
        CFG_STEP_SCALE: step_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // character classes
  assign is_digit  = (in_rx_byte >= CHAR_ZERO) && (in_rx_byte <= CHAR_NINE);
  assign is_space  = (in_rx_byte == CHAR_SPACE) ||
                     ((in_rx_byte >= CHAR_TAB) && (in_rx_byte <= CHAR_CR));
  assign digit_val = ValueWidth'(in_rx_byte - CHAR_ZERO);

  // frame_start always restarts at the letter position
  assign pos_sel = in_frame_start ? '0 : pos_r;

  // range check and substitution on the lf byte
  assign frame_ok = cr_r && (in_rx_byte == CHAR_LF) && (is_s_r || is_d_r);
  always_comb begin
    cmd_val = acc_r;
    if ((neg_r && (acc_r != '0)) || (acc_r > max_value_r)) begin
      cmd_val = max_value_r >> 1;
    end
  end

  // (value - zero) * step, rounded half up to q.14, saturated
  assign diff     = $signed({1'b0, cmd_val}) - $signed({2'b00, zero_value_r});
  assign prod     = ProdWidth'(diff) * $signed({1'b0, step_scale_r});
  assign prod_rnd = prod + ProdWidth'(1 << (FracDrop - 1));
  assign q        = QWidth'(prod_rnd >>> FracDrop);

  always_comb begin
    if (q > QWidth'(32767)) begin
      target = 16'sh7FFF;
    end else if (q < -QWidth'(32768)) begin
      target = 16'sh8000;
    end else begin
      target = q[TargetWidth-1:0];
    end
  end

  // frame sequencing and atoi scan
  always_comb begin
    pos_nxt       = pos_r;
    is_s_nxt      = is_s_r;
    is_d_nxt      = is_d_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    cr_nxt        = cr_r;
    speed_nxt     = speed_r;
    rot_nxt       = rot_r;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    out_valid_nxt = out_valid_r & out_stall;

    if (in_acc && (pos_sel != POS_IDLE)) begin
      if (pos_sel == '0) begin
        // command letter opens the frame
        is_s_nxt  = (in_rx_byte == CHAR_S);
        is_d_nxt  = (in_rx_byte == CHAR_D);
        phase_nxt = PH_SKIP;
        neg_nxt   = 1'b0;
        acc_nxt   = '0;
        cr_nxt    = 1'b0;
        pos_nxt   = PosWidth'(1);
      end else if (pos_sel < POS_CR) begin
        // value characters
        pos_nxt = pos_sel + PosWidth'(1);
        if (phase_r != PH_DONE) begin
          if (is_digit) begin
            acc_nxt   = (acc_r << 3) + (acc_r << 1) + digit_val;
            phase_nxt = PH_DIGITS;
          end else if ((phase_r == PH_SKIP) && is_space) begin
            phase_nxt = PH_SKIP;
          end else if ((phase_r == PH_SKIP) &&
                       ((in_rx_byte == CHAR_PLUS) || (in_rx_byte == CHAR_MINUS))) begin
            neg_nxt   = (in_rx_byte == CHAR_MINUS);
            phase_nxt = PH_SIGNED;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
      end else if (pos_sel == POS_CR) begin
        cr_nxt  = (in_rx_byte == CHAR_CR);
        pos_nxt = POS_LF;
      end else begin
        // lf byte closes the frame and always gives a result
        pos_nxt       = POS_IDLE;
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_REJECT;
        value_nxt     = '0;
        if (frame_ok) begin
          value_nxt = cmd_val;
          if (is_s_r) begin
            speed_nxt = target;
            kind_nxt  = KIND_SPEED;
          end else begin
            rot_nxt  = target;
            kind_nxt = KIND_ROTATION;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_IDLE;
      is_s_r      <= 1'b0;
      is_d_r      <= 1'b0;
      phase_r     <= PH_SKIP;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      cr_r        <= 1'b0;
      speed_r     <= '0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      is_s_r      <= is_s_nxt;
      is_d_r      <= is_d_nxt;
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      cr_r        <= cr_nxt;
      speed_r     <= speed_nxt;
      rot_r       <= rot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
  end

endmodule

[design/ccfp_checker.sv]
// ----------------------------------------------------------------------------
// ccfp_checker: port-level checks of the command frame parser
// Watches handshakes and result fields over time; bound to the top level.
// ----------------------------------------------------------------------------
module ccfp_checker
  import ccfp_pkg::*;
(
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    out_command_kind,
  input logic [ValueWidth-1:0]         out_command_value,
  input logic signed [TargetWidth-1:0] out_speed_target,
  input logic signed [TargetWidth-1:0] out_rotation_target
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_command_kind) &&
    $stable(out_command_value))
    else $error("result changed while stalled");

  // input only stalls behind a held result
  a_no_extra_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled with free output register");

  // rejected frames report value zero
  a_reject_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command_kind == KIND_REJECT) |-> out_command_value == '0)
    else $error("rejected frame with nonzero value");

  // a target moves only with a matching new result
  a_speed_move: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(out_speed_target) |-> out_valid && (out_command_kind == KIND_SPEED))
    else $error("speed target moved without speed result");

  a_rot_move: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(out_rotation_target) |-> out_valid && (out_command_kind == KIND_ROTATION))
    else $error("rotation target moved without rotation result");

endmodule

bind control_command_frame_parser_core ccfp_checker u_ccfp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_command_kind    (out_command_kind),
  .out_command_value   (out_command_value),
  .out_speed_target    (out_speed_target),
  .out_rotation_target (out_rotation_target)
);
